@@ hw/rtl/rpd_pkg.sv @@
package rpd_pkg;

  localparam int unsigned PixBits   = 21;
  localparam int unsigned RgbBits   = 24;
  localparam int unsigned RunBits   = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  localparam logic [7:0] RepeatFlagMask = 8'h80;
  localparam logic [7:0] CountMask      = 8'h7f;

  // one decoded result as it travels from the front end to the output stage
  typedef struct packed {
    logic [RgbBits-1:0] rgb;
    logic [PixBits-1:0] start;
    logic [RunBits-1:0] run;
    logic               done;
  } result_t;

endpackage

@@ hw/rtl/rpd_if.sv @@
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_image;

  modport source (output valid, output data_byte, output first_of_image, input ready);
  modport sink   (input valid, input data_byte, input first_of_image, output ready);
endinterface

interface rpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] image_pixels;

  modport source (output valid, output image_pixels, input ready);
  modport sink   (input valid, input image_pixels, output ready);
endinterface

interface rpd_out_if #(
  parameter int unsigned INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [23:0]           pixel_rgb;
  logic [INDEX_BITS-1:0] start_index;
  logic [7:0]            run_length;
  logic                  image_done;

  modport source (output valid, output pixel_rgb, output start_index, output run_length,
                  output image_done, input ready);
  modport sink   (input valid, input pixel_rgb, input start_index, input run_length,
                  input image_done, output ready);
endinterface

@@ hw/rtl/rpd_front.sv @@
module rpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpd_in_if.sink           in_i,
  rpd_cfg_if.sink          cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rpd_pkg::result_t push_data_o
);
  import rpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BYTE1,
    PH_BYTE2,
    PH_BYTE3
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 rep_q, rep_d;
  logic [RunBits-1:0]   left_q, left_d;
  logic [15:0]          acc_q, acc_d;
  logic [PixBits-1:0]   ctr_q, ctr_d;
  logic                 fin_q, fin_d;
  logic [PixBits-1:0]   img_q;

  logic                 accept;
  phase_e               phase_eff;
  logic [PixBits-1:0]   ctr_eff;
  logic                 fin_eff;
  logic [PixBits-1:0]   avail;
  logic [RunBits-1:0]   count;
  logic [RunBits-1:0]   run;
  logic [PixBits-1:0]   ctr_next;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  // a restart byte wipes progress and is taken as a header
  assign phase_eff = in_i.first_of_image ? PH_HEADER : phase_q;
  assign ctr_eff   = in_i.first_of_image ? '0 : ctr_q;
  assign fin_eff   = in_i.first_of_image ? 1'b0 : fin_q;

  assign avail    = img_q - ctr_eff;
  assign run      = rep_q ? left_q : RunBits'(1);
  assign ctr_next = ctr_eff + PixBits'(run);

  always_comb begin
    count = RunBits'(in_i.data_byte & CountMask) + RunBits'(1);
    if (PixBits'(count) > avail) begin
      count = avail[RunBits-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_eff;
    rep_d       = rep_q;
    left_d      = left_q;
    acc_d       = acc_q;
    ctr_d       = ctr_eff;
    fin_d       = fin_eff;
    push_o      = 1'b0;
    push_data_o = '{rgb: {acc_q, in_i.data_byte}, start: ctr_eff, run: run,
                    done: (ctr_next >= img_q)};
    if (!fin_eff) begin
      case (phase_eff)
        PH_HEADER: begin
          if (img_q <= ctr_eff) begin
            fin_d = 1'b1;
          end else begin
            rep_d   = |(in_i.data_byte & RepeatFlagMask);
            left_d  = count;
            phase_d = PH_BYTE1;
          end
        end
        PH_BYTE1: begin
          acc_d   = {8'h00, in_i.data_byte};
          phase_d = PH_BYTE2;
        end
        PH_BYTE2: begin
          acc_d   = {acc_q[7:0], in_i.data_byte};
          phase_d = PH_BYTE3;
        end
        PH_BYTE3: begin
          left_d  = rep_q ? '0 : left_q - RunBits'(1);
          ctr_d   = ctr_next;
          phase_d = (left_d == '0) ? PH_HEADER : PH_BYTE1;
          fin_d   = (ctr_next >= img_q);
          push_o  = accept;
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      rep_q   <= 1'b0;
      left_q  <= '0;
      acc_q   <= '0;
      ctr_q   <= '0;
      fin_q   <= 1'b0;
      img_q   <= PixBits'(1);
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        rep_q   <= rep_d;
        left_q  <= left_d;
        acc_q   <= acc_d;
        ctr_q   <= ctr_d;
        fin_q   <= fin_d;
      end
      if (cfg_i.valid) begin
        img_q <= cfg_i.image_pixels;
      end
    end
  end

  // a completed pixel always returns to a byte phase of the next pixel or a header
  a_push_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (phase_q == PH_HEADER || phase_q == PH_BYTE1))
    else $error("bad phase after pixel");

  a_push_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.done) |=> fin_q)
    else $error("image_done without finish");

  a_fin_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && !in_i.first_of_image) |-> !push_o)
    else $error("result after finish");

endmodule

@@ hw/rtl/rpd_queue.sv @@
module rpd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rpd_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rpd_pkg::result_t pop_data_o
);
  import rpd_pkg::*;

  result_t                mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wptr_q, rptr_q;
  logic [QueuePtrBits:0]   cnt_q;

  assign full_o     = (cnt_q == (QueuePtrBits+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QueuePtrBits'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueuePtrBits'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QueuePtrBits+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QueuePtrBits+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[QueuePtrBits-1:0])
    else $error("pointers disagree with fill count");

endmodule

@@ hw/rtl/rpd_back.sv @@
module rpd_back #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rpd_pkg::result_t pop_data_i,
  output logic             pop_o,
  rpd_out_if.source        out_o
);
  import rpd_pkg::*;

  logic                  valid_q;
  logic [RgbBits-1:0]    rgb_q;
  logic [INDEX_BITS-1:0] start_q;
  logic [RunBits-1:0]    run_q;
  logic                  done_q;

  // refill the output register whenever it is empty or being taken
  assign pop_o = !empty_i && (!valid_q || out_o.ready);

  assign out_o.valid       = valid_q;
  assign out_o.pixel_rgb   = rgb_q;
  assign out_o.start_index = start_q;
  assign out_o.run_length  = run_q;
  assign out_o.image_done  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rgb_q   <= pop_data_i.rgb;
      start_q <= INDEX_BITS'(pop_data_i.start);
      run_q   <= pop_data_i.run;
      done_q  <= pop_data_i.done;
    end
  end

endmodule

@@ hw/rtl/rle_pixel_run_decoder.sv @@
// Run-length pixel decoder for 24-bit packet streams: one compressed byte is taken per clock
// on in_i while in_i.ready is high, and a repeat run or raw pixel leaves on out_o as one
// item once its third pixel byte is in, via the result queue and output register. in_i.ready
// falls only when the four-item result queue is full, i.e. when out_o has been stalled;
// otherwise the block sustains one byte per cycle. The user writes image_pixels over cfg_i
// between images (unenforced); a first_of_image byte restarts decoding at pixel zero.
module rle_pixel_run_decoder #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpd_in_if.sink    in_i,
  rpd_cfg_if.sink   cfg_i,
  rpd_out_if.source out_o
);
  import rpd_pkg::*;

  logic    push, q_full, pop, q_empty;
  result_t push_data, pop_data;

  rpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  rpd_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
